// File: src/ook_pulse_width_command_sender_assert.svh
// Assertion macros for the on-off keyed command sender.
`ifndef OOK_PULSE_WIDTH_COMMAND_SENDER_ASSERT_SVH
`define OOK_PULSE_WIDTH_COMMAND_SENDER_ASSERT_SVH

// Condition in the same cycle implies the consequence.
`define OOKPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies the consequence in the next cycle.
`define OOKPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ookpw_pkg.sv
// Shared constants, types and helper functions of the on-off keyed command sender.
`timescale 1ns / 1ps
`default_nettype none

package ookpw_pkg;

   localparam int COMMAND_BITS   = 15;
   localparam int DURATION_WIDTH = 16;

   localparam int BIT_IDX_W   = $clog2(COMMAND_BITS + 1);
   localparam int CMD_IDX_W   = $clog2(COMMAND_BITS);
   localparam int CFG_W       = 16;
   localparam int REPEAT_W    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int RAW_W       = 14;
   localparam int WIDE_W      = (COMMAND_BITS > RAW_W) ? COMMAND_BITS : RAW_W;
   localparam int LOAD_W      = (DURATION_WIDTH > CFG_W) ? DURATION_WIDTH : CFG_W;

   // Request opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MARK       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_SPACE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_SPACE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRE_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRE_LOW    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_SPACE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT     = 3'd6;

   // Register reset values
   localparam logic [CFG_W-1:0]    MARK_RESET       = 16'd372;
   localparam logic [CFG_W-1:0]    ONE_SPACE_RESET  = 16'd1493;
   localparam logic [CFG_W-1:0]    ZERO_SPACE_RESET = 16'd498;
   localparam logic [CFG_W-1:0]    PRE_HIGH_RESET   = 16'd9201;
   localparam logic [CFG_W-1:0]    PRE_LOW_RESET    = 16'd2614;
   localparam logic [CFG_W-1:0]    STOP_SPACE_RESET = 16'd4850;
   localparam logic [REPEAT_W-1:0] REPEAT_RESET     = 8'd20;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic done_res;
      logic dropped;
   } rsp_type;

   // On word: bits 13 and 12 set, then mode, rotation, timer, speed.
   function automatic logic [COMMAND_BITS-1:0] build_word(
      input logic       power_on,
      input logic [3:0] speed,
      input logic [3:0] timer,
      input logic [1:0] rotation,
      input logic [1:0] mode
   );
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'({2'b11, mode, rotation, timer, speed});
      if (!power_on) begin
         wide = '0;
      end
      return wide[COMMAND_BITS-1:0];
   endfunction

   // Zero lasts one tick; saturate what the counter cannot hold.
   function automatic logic [DURATION_WIDTH-1:0] load_duration(input logic [CFG_W-1:0] v);
      logic [LOAD_W-1:0] v_wide;
      logic [LOAD_W-1:0] dmax_wide;
      logic [DURATION_WIDTH-1:0] res;
      v_wide    = LOAD_W'(v);
      dmax_wide = LOAD_W'({DURATION_WIDTH{1'b1}});
      if (v == '0) begin
         res = DURATION_WIDTH'(1);
      end else if (v_wide > dmax_wide) begin
         res = '1;
      end else begin
         res = v_wide[DURATION_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/ook_pulse_width_command_sender.sv
// Top level of the on-off keyed command sender: frame sequencer and output buffer.
`timescale 1ns / 1ps
`default_nettype none

// Every request gives exactly one result. A request with op = tick advances the pin
// timing by one microsecond; op = send loads a command frame when idle and is dropped
// (flagged in the result) when a transmission is running. Each request is handled in
// the cycle it is accepted and its result is registered and offered on rsp_, so one
// request per cycle is sustained while results are taken. Results land in a two-entry
// output buffer: req_ready drops only while both entries hold results that the result
// side has not taken. Registers are written through the csr_ port, which is always
// ready; write them only while no transmission is running.
`include "ook_pulse_width_command_sender_assert.svh"

module ook_pulse_width_command_sender (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_op,
   input  wire logic                                  req_power_on,
   input  wire logic [3:0]                            req_speed,
   input  wire logic [3:0]                            req_timer,
   input  wire logic [1:0]                            req_rotation,
   input  wire logic [1:0]                            req_mode,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_pin_level,
   output logic                                       rsp_busy_res,
   output logic                                       rsp_done_res,
   output logic                                       rsp_dropped,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ookpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ookpw_pkg::CFG_W-1:0]           csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_PRE_HIGH   = 3'd1,
      PH_PRE_LOW    = 3'd2,
      PH_BIT_MARK   = 3'd3,
      PH_BIT_SPACE  = 3'd4,
      PH_STOP_MARK  = 3'd5,
      PH_STOP_SPACE = 3'd6
   } phase_type;

   // Configuration
   logic [ookpw_pkg::CFG_W-1:0]    mark_ff;
   logic [ookpw_pkg::CFG_W-1:0]    one_space_ff;
   logic [ookpw_pkg::CFG_W-1:0]    zero_space_ff;
   logic [ookpw_pkg::CFG_W-1:0]    pre_high_ff;
   logic [ookpw_pkg::CFG_W-1:0]    pre_low_ff;
   logic [ookpw_pkg::CFG_W-1:0]    stop_space_ff;
   logic [ookpw_pkg::REPEAT_W-1:0] repeat_ff;

   // Sequencer state
   phase_type                             phase_ff, phase_in;
   logic [ookpw_pkg::COMMAND_BITS-1:0]    command_word_ff, command_word_in;
   logic [ookpw_pkg::BIT_IDX_W-1:0]       bit_index_ff, bit_index_in;
   logic [ookpw_pkg::DURATION_WIDTH-1:0]  duration_ff, duration_in;
   logic [ookpw_pkg::REPEAT_W-1:0]        repeats_ff, repeats_in;

   // Output buffer
   ookpw_pkg::rsp_type out_ff, skid_ff, rsp_in;
   logic               out_valid_ff, skid_valid_ff;

   logic req_fire;
   logic rsp_pop;
   logic level;
   logic cur_bit;
   logic dur_expired;
   logic last_repeat;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_pop   = out_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   assign rsp_pin_level = out_ff.pin_level;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_dropped   = out_ff.dropped;

   always_comb begin
      level = (phase_ff inside {PH_PRE_HIGH, PH_BIT_MARK, PH_STOP_MARK});
      if (bit_index_ff >= ookpw_pkg::BIT_IDX_W'(ookpw_pkg::COMMAND_BITS)) begin
         cur_bit = 1'b1;   // start bit
      end else begin
         cur_bit = command_word_ff[bit_index_ff[ookpw_pkg::CMD_IDX_W-1:0]];
      end
      dur_expired = (duration_ff == '0) || (duration_ff == ookpw_pkg::DURATION_WIDTH'(1));
      last_repeat = (repeats_ff == '0) || (repeats_ff == ookpw_pkg::REPEAT_W'(1));
   end

   always_comb begin
      phase_in        = phase_ff;
      command_word_in = command_word_ff;
      bit_index_in    = bit_index_ff;
      duration_in     = duration_ff;
      repeats_in      = repeats_ff;
      rsp_in          = '0;
      if (req_fire) begin
         if (req_op == ookpw_pkg::OP_SEND) begin
            if (phase_ff != PH_IDLE) begin
               rsp_in.dropped   = 1'b1;
               rsp_in.pin_level = level;
               rsp_in.busy_res  = 1'b1;
            end else begin
               command_word_in  = ookpw_pkg::build_word(req_power_on, req_speed, req_timer,
                                                        req_rotation, req_mode);
               repeats_in       = (repeat_ff == '0) ? ookpw_pkg::REPEAT_W'(1) : repeat_ff;
               bit_index_in     = '0;
               phase_in         = PH_PRE_HIGH;
               duration_in      = ookpw_pkg::load_duration(pre_high_ff);
               rsp_in.pin_level = 1'b1;
               rsp_in.busy_res  = 1'b1;
            end
         end else if (phase_ff != PH_IDLE) begin
            rsp_in.pin_level = level;
            rsp_in.busy_res  = 1'b1;
            if (duration_ff != '0) begin
               duration_in = duration_ff - ookpw_pkg::DURATION_WIDTH'(1);
            end
            if (dur_expired) begin
               case (phase_ff)
                  PH_PRE_HIGH: begin
                     phase_in    = PH_PRE_LOW;
                     duration_in = ookpw_pkg::load_duration(pre_low_ff);
                  end
                  PH_PRE_LOW: begin
                     bit_index_in = ookpw_pkg::BIT_IDX_W'(ookpw_pkg::COMMAND_BITS);
                     phase_in     = PH_BIT_MARK;
                     duration_in  = ookpw_pkg::load_duration(mark_ff);
                  end
                  PH_BIT_MARK: begin
                     phase_in    = PH_BIT_SPACE;
                     duration_in = ookpw_pkg::load_duration(cur_bit ? one_space_ff
                                                                    : zero_space_ff);
                  end
                  PH_BIT_SPACE: begin
                     if (bit_index_ff == '0) begin
                        phase_in = PH_STOP_MARK;
                     end else begin
                        bit_index_in = bit_index_ff - ookpw_pkg::BIT_IDX_W'(1);
                        phase_in     = PH_BIT_MARK;
                     end
                     duration_in = ookpw_pkg::load_duration(mark_ff);
                  end
                  PH_STOP_MARK: begin
                     phase_in    = PH_STOP_SPACE;
                     duration_in = ookpw_pkg::load_duration(stop_space_ff);
                  end
                  PH_STOP_SPACE: begin
                     if (repeats_ff != '0) begin
                        repeats_in = repeats_ff - ookpw_pkg::REPEAT_W'(1);
                     end
                     if (last_repeat) begin
                        phase_in        = PH_IDLE;
                        duration_in     = '0;
                        bit_index_in    = '0;
                        rsp_in.done_res = 1'b1;
                     end else begin
                        phase_in    = PH_PRE_HIGH;
                        duration_in = ookpw_pkg::load_duration(pre_high_ff);
                     end
                  end
                  default: begin
                     phase_in    = PH_IDLE;
                     duration_in = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff         <= ookpw_pkg::MARK_RESET;
         one_space_ff    <= ookpw_pkg::ONE_SPACE_RESET;
         zero_space_ff   <= ookpw_pkg::ZERO_SPACE_RESET;
         pre_high_ff     <= ookpw_pkg::PRE_HIGH_RESET;
         pre_low_ff      <= ookpw_pkg::PRE_LOW_RESET;
         stop_space_ff   <= ookpw_pkg::STOP_SPACE_RESET;
         repeat_ff       <= ookpw_pkg::REPEAT_RESET;
         phase_ff        <= PH_IDLE;
         command_word_ff <= '0;
         bit_index_ff    <= '0;
         duration_ff     <= '0;
         repeats_ff      <= '0;
         out_ff          <= '0;
         skid_ff         <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ookpw_pkg::REG_MARK:       mark_ff       <= csr_data;
               ookpw_pkg::REG_ONE_SPACE:  one_space_ff  <= csr_data;
               ookpw_pkg::REG_ZERO_SPACE: zero_space_ff <= csr_data;
               ookpw_pkg::REG_PRE_HIGH:   pre_high_ff   <= csr_data;
               ookpw_pkg::REG_PRE_LOW:    pre_low_ff    <= csr_data;
               ookpw_pkg::REG_STOP_SPACE: stop_space_ff <= csr_data;
               ookpw_pkg::REG_REPEAT:     repeat_ff     <= csr_data[ookpw_pkg::REPEAT_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff        <= phase_in;
         command_word_ff <= command_word_in;
         bit_index_ff    <= bit_index_in;
         duration_ff     <= duration_in;
         repeats_ff      <= repeats_in;
         // Two-entry output buffer: skid holds a result while the output entry is stalled.
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_fire) begin
            if (!out_valid_ff || rsp_pop) begin
               out_ff       <= rsp_in;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= rsp_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `OOKPW_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry holds a result while the output entry is empty")
   `OOKPW_ASSERT_NOW(a_active_has_time, clock, reset, phase_ff != PH_IDLE,
      duration_ff != '0, "active phase with no time left")
   `OOKPW_ASSERT_NOW(a_idle_index_clear, clock, reset, phase_ff == PH_IDLE,
      bit_index_ff == '0, "bit index not cleared while idle")
   `OOKPW_ASSERT_NEXT(a_done_goes_idle, clock, reset, req_fire && rsp_in.done_res,
      phase_ff == PH_IDLE, "done reported but sequencer still active")

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for the on-off keyed command sender: directed and random frames checked tick by tick.
`timescale 1ns / 1ps

module testbench;

   localparam int         STALL_LIMIT  = 20000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         RANDOM_TICKS = 100;
   localparam logic [2:0] REG_NONE     = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PRE_HIGH,
      PH_PRE_LOW,
      PH_BIT_MARK,
      PH_BIT_SPACE,
      PH_STOP_MARK,
      PH_STOP_SPACE
   } frame_phase_type;

   typedef struct packed {
      logic       op;
      logic       power_on;
      logic [3:0] speed;
      logic [3:0] timer;
      logic [1:0] rotation;
      logic [1:0] mode;
   } request_type;

   class pin_schedule_type;
      logic [15:0]                        mark_len;
      logic [15:0]                        one_len;
      logic [15:0]                        zero_len;
      logic [15:0]                        pre_high_len;
      logic [15:0]                        pre_low_len;
      logic [15:0]                        stop_len;
      logic [7:0]                         repeat_cfg;
      logic [ookpw_pkg::COMMAND_BITS-1:0] word;
      frame_phase_type                    phase;
      int unsigned                        bit_idx;
      logic [15:0]                        ticks_left;
      logic [7:0]                         frames_left;
      ookpw_pkg::rsp_type                 levels_due[$];
      int unsigned                        mismatch_count;

      function new();
         mark_len       = ookpw_pkg::MARK_RESET;
         one_len        = ookpw_pkg::ONE_SPACE_RESET;
         zero_len       = ookpw_pkg::ZERO_SPACE_RESET;
         pre_high_len   = ookpw_pkg::PRE_HIGH_RESET;
         pre_low_len    = ookpw_pkg::PRE_LOW_RESET;
         stop_len       = ookpw_pkg::STOP_SPACE_RESET;
         repeat_cfg     = ookpw_pkg::REPEAT_RESET;
         word           = '0;
         phase          = PH_IDLE;
         bit_idx        = 0;
         ticks_left     = '0;
         frames_left    = '0;
         mismatch_count = 0;
      endfunction

      function void set_register(input logic [2:0] idx, input logic [15:0] data);
         case (idx)
            ookpw_pkg::REG_MARK:       mark_len     = data;
            ookpw_pkg::REG_ONE_SPACE:  one_len      = data;
            ookpw_pkg::REG_ZERO_SPACE: zero_len     = data;
            ookpw_pkg::REG_PRE_HIGH:   pre_high_len = data;
            ookpw_pkg::REG_PRE_LOW:    pre_low_len  = data;
            ookpw_pkg::REG_STOP_SPACE: stop_len     = data;
            ookpw_pkg::REG_REPEAT:     repeat_cfg   = data[7:0];
            default: ;
         endcase
      endfunction

      function bit idle();
         return phase == PH_IDLE;
      endfunction

      // A zero length still lasts one tick.
      function logic [15:0] span(input logic [15:0] v);
         return (v == '0) ? 16'd1 : v;
      endfunction

      // Start bit sits above the command bits and is always a one.
      function logic current_bit();
         if (bit_idx >= ookpw_pkg::COMMAND_BITS) return 1'b1;
         return word[bit_idx];
      endfunction

      function logic drives_high();
         return phase == PH_PRE_HIGH || phase == PH_BIT_MARK || phase == PH_STOP_MARK;
      endfunction

      function void enter_phase(input frame_phase_type target);
         phase = target;
         case (target)
            PH_PRE_HIGH:   ticks_left = span(pre_high_len);
            PH_PRE_LOW:    ticks_left = span(pre_low_len);
            PH_BIT_MARK,
            PH_STOP_MARK:  ticks_left = span(mark_len);
            PH_BIT_SPACE:  ticks_left = span(current_bit() ? one_len : zero_len);
            PH_STOP_SPACE: ticks_left = span(stop_len);
            default:       ticks_left = '0;
         endcase
      endfunction

      function void accept_request(input request_type rq);
         ookpw_pkg::rsp_type due;
         logic [31:0]        wide;
         due = '0;
         if (rq.op == ookpw_pkg::OP_SEND) begin
            if (phase != PH_IDLE) begin
               due.dropped = 1'b1;
            end else begin
               wide = rq.power_on ?
                  {18'd0, 2'b11, rq.mode, rq.rotation, rq.timer, rq.speed} : 32'd0;
               word        = wide[ookpw_pkg::COMMAND_BITS-1:0];
               frames_left = (repeat_cfg == '0) ? 8'd1 : repeat_cfg;
               bit_idx     = 0;
               enter_phase(PH_PRE_HIGH);
            end
            due.pin_level = drives_high();
            due.busy_res  = (phase != PH_IDLE);
         end else if (phase != PH_IDLE) begin
            due.pin_level = drives_high();
            due.busy_res  = 1'b1;
            if (ticks_left != '0) ticks_left--;
            if (ticks_left == '0) begin
               case (phase)
                  PH_PRE_HIGH: enter_phase(PH_PRE_LOW);
                  PH_PRE_LOW: begin
                     bit_idx = ookpw_pkg::COMMAND_BITS;
                     enter_phase(PH_BIT_MARK);
                  end
                  PH_BIT_MARK: enter_phase(PH_BIT_SPACE);
                  PH_BIT_SPACE: begin
                     if (bit_idx == 0) begin
                        enter_phase(PH_STOP_MARK);
                     end else begin
                        bit_idx--;
                        enter_phase(PH_BIT_MARK);
                     end
                  end
                  PH_STOP_MARK: enter_phase(PH_STOP_SPACE);
                  default: begin
                     if (frames_left != '0) frames_left--;
                     if (frames_left == '0) begin
                        enter_phase(PH_IDLE);
                        bit_idx      = 0;
                        due.done_res = 1'b1;
                     end else begin
                        enter_phase(PH_PRE_HIGH);
                     end
                  end
               endcase
            end
         end
         levels_due.push_back(due);
      endfunction

      function void match_result(input ookpw_pkg::rsp_type got);
         ookpw_pkg::rsp_type due;
         if (levels_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: result with no request waiting:", $time);
               $display("%0t:           got      pin=%0b busy=%0b done=%0b dropped=%0b",
                        $time, got.pin_level, got.busy_res, got.done_res, got.dropped);
            end
            return;
         end
         due = levels_due.pop_front();
         if (got.pin_level !== due.pin_level || got.busy_res !== due.busy_res ||
             got.done_res !== due.done_res || got.dropped !== due.dropped) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: mismatch: expected pin=%0b busy=%0b done=%0b dropped=%0b",
                        $time, due.pin_level, due.busy_res, due.done_res, due.dropped);
               $display("%0t:           got      pin=%0b busy=%0b done=%0b dropped=%0b",
                        $time, got.pin_level, got.busy_res, got.done_res, got.dropped);
            end
         end
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset        = 1'b1;
   logic                                   req_valid    = 1'b0;
   logic                                   req_ready;
   logic                                   req_op       = 1'b0;
   logic                                   req_power_on = 1'b0;
   logic [3:0]                             req_speed    = '0;
   logic [3:0]                             req_timer    = '0;
   logic [1:0]                             req_rotation = '0;
   logic [1:0]                             req_mode     = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready    = 1'b0;
   logic                                   rsp_pin_level;
   logic                                   rsp_busy_res;
   logic                                   rsp_done_res;
   logic                                   rsp_dropped;
   logic                                   csr_valid    = 1'b0;
   logic                                   csr_ready;
   logic [ookpw_pkg::CSR_INDEX_W-1:0]      csr_index    = '0;
   logic [ookpw_pkg::CFG_W-1:0]            csr_data     = '0;

   ookpw_pkg::rsp_type rsp_seen;
   pin_schedule_type   sched;
   bit                 throttle_on  = 1'b1;
   bit                 hold_results = 1'b0;
   int unsigned        busy_ticks   = 0;
   int unsigned        quiet_cycles = 0;

   assign rsp_seen = {rsp_pin_level, rsp_busy_res, rsp_done_res, rsp_dropped};

   ook_pulse_width_command_sender u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_power_on (req_power_on),
      .req_speed    (req_speed),
      .req_timer    (req_timer),
      .req_rotation (req_rotation),
      .req_mode     (req_mode),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pin_level(rsp_pin_level),
      .rsp_busy_res (rsp_busy_res),
      .rsp_done_res (rsp_done_res),
      .rsp_dropped  (rsp_dropped),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sched.match_result(rsp_seen);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL ook_pulse_width_command_sender");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : result_sink
      int unsigned n;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_results) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else if (throttle_on && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic request_type make_tick();
      request_type rq;
      rq.op       = ookpw_pkg::OP_TICK;
      rq.power_on = 1'($urandom);
      rq.speed    = 4'($urandom);
      rq.timer    = 4'($urandom);
      rq.rotation = 2'($urandom);
      rq.mode     = 2'($urandom);
      return rq;
   endfunction

   function automatic request_type make_send(input logic power_on, input logic [3:0] speed,
                                             input logic [3:0] timer,
                                             input logic [1:0] rotation,
                                             input logic [1:0] mode);
      request_type rq;
      rq.op       = ookpw_pkg::OP_SEND;
      rq.power_on = power_on;
      rq.speed    = speed;
      rq.timer    = timer;
      rq.rotation = rotation;
      rq.mode     = mode;
      return rq;
   endfunction

   function automatic request_type random_send();
      return make_send($urandom_range(0, 3) != 0, 4'($urandom), 4'($urandom),
                       2'($urandom), 2'($urandom));
   endfunction

   function automatic logic [15:0] pick_len();
      if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 3));
      return 16'($urandom_range(4, 12));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_request(input request_type rq);
      req_valid    = 1'b1;
      req_op       = rq.op;
      req_power_on = rq.power_on;
      req_speed    = rq.speed;
      req_timer    = rq.timer;
      req_rotation = rq.rotation;
      req_mode     = rq.mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sched.accept_request(rq);
      @(negedge clock);
   endtask

   task automatic sender_pause();
      int unsigned n;
      if (throttle_on && $urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 13);
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sched.levels_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sched.set_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_timing(input logic [15:0] mark, input logic [15:0] one,
                             input logic [15:0] zero, input logic [15:0] pre_high,
                             input logic [15:0] pre_low, input logic [15:0] stop,
                             input logic [15:0] frames);
      wait_drained();
      write_reg(ookpw_pkg::REG_MARK, mark);
      write_reg(ookpw_pkg::REG_ONE_SPACE, one);
      write_reg(ookpw_pkg::REG_ZERO_SPACE, zero);
      write_reg(ookpw_pkg::REG_PRE_HIGH, pre_high);
      write_reg(ookpw_pkg::REG_PRE_LOW, pre_low);
      write_reg(ookpw_pkg::REG_STOP_SPACE, stop);
      write_reg(ookpw_pkg::REG_REPEAT, frames);
   endtask

   // Tick until the transmission ends; now and then throw in a send that must be dropped.
   task automatic finish_frame();
      while (!sched.idle()) begin
         sender_pause();
         if ($urandom_range(0, 39) == 0) begin
            push_request(random_send());
         end else begin
            push_request(make_tick());
         end
         busy_ticks++;
      end
   endtask

   task automatic random_timing();
      logic [7:0] frames;
      frames = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                 {8'($urandom), frames});
   endtask

   initial begin : stimulus
      int unsigned random_start;
      bit          held;
      sched = new();
      held  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Ticks while idle, then one short frame.
      push_request(make_tick());
      push_request(make_tick());
      set_timing(16'd2, 16'd1, 16'd1, 16'd3, 16'd2, 16'd2, 16'd1);
      push_request(make_send(1'b1, 4'hF, 4'hF, 2'h3, 2'h3));
      push_request(make_tick());
      push_request(make_send(1'b0, 4'h0, 4'h0, 2'h0, 2'h0));
      push_request(make_send(1'b1, 4'h5, 4'hA, 2'h1, 2'h2));
      finish_frame();
      push_request(make_tick());

      // Zero lengths, zero repeat count with junk in the upper bits, unused index.
      set_timing(16'd0, 16'd2, 16'd1, 16'd0, 16'd1, 16'd3, 16'hFF00);
      write_reg(REG_NONE, 16'hFFFF);
      push_request(make_send(1'b0, 4'hF, 4'hF, 2'h3, 2'h3));
      push_request(make_tick());
      push_request(make_tick());
      push_request(make_send(1'b1, 4'hF, 4'h0, 2'h3, 2'h0));
      finish_frame();

      // On word with all settings zero, three frames.
      set_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd0, 16'd1, 16'd3);
      push_request(make_send(1'b1, 4'h0, 4'h0, 2'h0, 2'h0));
      finish_frame();
      push_request(make_tick());

      random_start = busy_ticks;
      while (busy_ticks - random_start < RANDOM_TICKS) begin
         random_timing();
         repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(0, 2)) push_request(make_tick());
            // Hold the result side off once so the output buffer fills and stalls requests.
            if (!held) begin
               hold_results = 1'b1;
               held         = 1'b1;
            end
            push_request(random_send());
            finish_frame();
         end
      end

      // Last stretch runs without idling: two frames back to back, then long lengths.
      throttle_on = 1'b0;
      set_timing(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1, 16'd2);
      push_request(random_send());
      finish_frame();
      set_timing(16'd1, 16'd1, 16'd24, 16'd24, 16'd24, 16'd24, 16'd1);
      push_request(make_send(1'b1, 4'hF, 4'hF, 2'h3, 2'h3));
      finish_frame();
      set_timing(16'd1, 16'd24, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      push_request(make_send(1'b0, 4'h0, 4'h0, 2'h0, 2'h0));
      finish_frame();

      wait_drained();
      repeat (20) @(posedge clock);
      if (sched.mismatch_count == 0 && sched.levels_due.size() == 0) begin
         $display("PASS ook_pulse_width_command_sender");
      end else begin
         $display("FAIL ook_pulse_width_command_sender");
      end
      $finish;
   end

endmodule
